// File: rtl/karplus_strong_noise_snare_core_macros.svh
// Assertion macros for the checker file of the snare core.
`ifndef KARPLUS_STRONG_NOISE_SNARE_CORE_MACROS_SVH
`define KARPLUS_STRONG_NOISE_SNARE_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define KSNS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snare core check failed");

// Check a consequent in the cycle after its antecedent.
`define KSNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snare core check failed");

`endif

// File: rtl/ksns_pkg.sv
package ksns_pkg;

    // Noise generator step and table fill values
    localparam logic [31:0] NOISE_MULT = 32'd1103515245;
    localparam logic [15:0] FILL_BASE  = 16'h4000;

    // Register reset values
    localparam logic [31:0] SEED_RESET = 32'd44100;
    localparam logic [15:0] GAIN_RESET = 16'd32768;

    // Output sample limits
    localparam logic [14:0] SAMPLE_MAX = 15'h3fff;
    localparam logic [14:0] SAMPLE_MIN = 15'h4000;

    // Configuration register indexes
    localparam logic REG_NOISE_SEED = 1'b0;
    localparam logic REG_OUT_GAIN   = 1'b1;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FILL  = 6'b000010,
        S_RD0   = 6'b000100,
        S_RD1   = 6'b001000,
        S_AVG   = 6'b010000,
        S_SCALE = 6'b100000
    } state_t;

    // Operations of the shared multiplier
    typedef enum logic [1:0] {
        MUL_NOISE = 2'b01,
        MUL_GAIN  = 2'b10
    } mul_op_t;

    typedef struct packed {
        mul_op_t            op;
        logic [31:0]        noise;
        logic signed [16:0] y;
        logic [15:0]        gain;
    } mul_req_t;

endpackage

// File: rtl/karplus_strong_noise_snare_core.sv
// Channel   Handshake              Payload
// input     in_valid / in_stall    restart (1 bit)
// output    out_valid / out_stall  sample (15 bit signed)
// config    cfg_we                 cfg_index (1 bit), cfg_data (32 bit)
//
// A sample goes through accept with first table read, second read, average and
// write-back, then gain multiply. The single table read port and the shared
// multiplier keep these steps apart. A restart, or the first item after reset,
// first fills all TABLE_DEPTH entries, one entry and one generator step a cycle.
// rst_n clears control state asynchronously; the table is only read after a fill.
// A stalled result holds in the output register; a finished sample waits
// in the gain stage until that register frees, and input stays stalled meanwhile.
module karplus_strong_noise_snare_core #(
    parameter int TABLE_DEPTH = 200
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [14:0] sample,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    ksns_pkg::state_t state_reg, state_next;

    logic [31:0]        seed_reg;
    logic [15:0]        gain_reg;
    logic [31:0]        noise_reg, noise_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [AW-1:0]      fill_reg, fill_next;
    logic               primed_reg, primed_next;
    logic [15:0]        cur_reg, cur_next;
    logic signed [16:0] y_reg, y_next;
    logic               out_valid_reg, out_valid_next;
    logic [14:0]        sample_reg, sample_next;

    logic               ram_we;
    logic [AW-1:0]      ram_wr_addr;
    logic [15:0]        ram_wr_data;
    logic               ram_re;
    logic [AW-1:0]      ram_rd_addr;
    logic [15:0]        ram_rd_data;

    ksns_pkg::mul_req_t mul_req;
    logic [31:0]        mul_prod;

    logic [AW-1:0]      pos_inc;
    logic signed [16:0] sum;
    logic signed [16:0] sum_adj;
    logic signed [16:0] avg;
    logic signed [15:0] q;
    logic [14:0]        q_sat;
    logic               accept;
    logic               out_free;

    ksns_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_re),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ksns_mul u_mul (
        .req  (mul_req),
        .prod (mul_prod)
    );

    assign in_stall  = (state_reg != ksns_pkg::S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    // Advance the read position with wrap
    assign pos_inc = (pos_reg == LAST_IDX) ? '0 : pos_reg + AW'(1);

    // Average current and next entries, truncating toward zero
    assign sum     = {cur_reg[15], cur_reg} + {ram_rd_data[15], ram_rd_data};
    assign sum_adj = sum + {16'd0, sum[16]};
    assign avg     = {sum_adj[16], sum_adj[16:1]};

    // Scale by gain, floor the shift and clamp to the sample range
    assign q = mul_prod[31:16];
    always_comb
    begin
        if (q[15] != q[14])
        begin
            q_sat = q[15] ? ksns_pkg::SAMPLE_MIN : ksns_pkg::SAMPLE_MAX;
        end
        else
        begin
            q_sat = q[14:0];
        end
    end

    // Drive the shared multiplier
    always_comb
    begin
        mul_req.noise = noise_reg;
        mul_req.y     = y_reg;
        mul_req.gain  = gain_reg;
        if (state_reg == ksns_pkg::S_SCALE)
        begin
            mul_req.op = ksns_pkg::MUL_GAIN;
        end
        else
        begin
            mul_req.op = ksns_pkg::MUL_NOISE;
        end
    end

    // Sequence fill and sample steps
    always_comb
    begin
        state_next     = state_reg;
        noise_next     = noise_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        primed_next    = primed_reg;
        cur_next       = cur_reg;
        y_next         = y_reg;
        sample_next    = sample_reg;
        out_valid_next = out_valid_reg && out_stall;
        ram_we         = 1'b0;
        ram_wr_addr    = fill_reg;
        ram_wr_data    = ksns_pkg::FILL_BASE + {2'b00, noise_reg[29:16]};
        ram_re         = 1'b0;
        ram_rd_addr    = pos_reg;

        case (state_reg)
            ksns_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (restart || !primed_reg)
                    begin
                        noise_next = seed_reg;
                        fill_next  = '0;
                        state_next = ksns_pkg::S_FILL;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = ksns_pkg::S_RD1;
                    end
                end
            end
            ksns_pkg::S_FILL:
            begin
                ram_we     = 1'b1;
                noise_next = mul_prod;
                fill_next  = fill_reg + AW'(1);
                if (fill_reg == LAST_IDX)
                begin
                    pos_next    = '0;
                    primed_next = 1'b1;
                    state_next  = ksns_pkg::S_RD0;
                end
            end
            ksns_pkg::S_RD0:
            begin
                ram_re     = 1'b1;
                state_next = ksns_pkg::S_RD1;
            end
            ksns_pkg::S_RD1:
            begin
                cur_next    = ram_rd_data;
                ram_re      = 1'b1;
                ram_rd_addr = pos_inc;
                state_next  = ksns_pkg::S_AVG;
            end
            ksns_pkg::S_AVG:
            begin
                y_next      = noise_reg[16] ? avg : -avg;
                ram_we      = 1'b1;
                ram_wr_addr = pos_reg;
                ram_wr_data = y_next[15:0];
                noise_next  = mul_prod;
                pos_next    = pos_inc;
                state_next  = ksns_pkg::S_SCALE;
            end
            ksns_pkg::S_SCALE:
            begin
                if (out_free)
                begin
                    sample_next    = q_sat;
                    out_valid_next = 1'b1;
                    state_next     = ksns_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ksns_pkg::S_IDLE;
            end
        endcase
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= ksns_pkg::SEED_RESET;
            gain_reg <= ksns_pkg::GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ksns_pkg::REG_NOISE_SEED: seed_reg <= cfg_data;
                ksns_pkg::REG_OUT_GAIN:   gain_reg <= cfg_data[15:0];
                default:                  seed_reg <= seed_reg;
            endcase
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ksns_pkg::S_IDLE;
            noise_reg     <= '0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            noise_reg     <= noise_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            primed_reg    <= primed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        y_reg      <= y_next;
        sample_reg <= sample_next;
    end

endmodule

// File: rtl/ksns_mul.sv
module ksns_mul (
    input  ksns_pkg::mul_req_t req,
    output logic [31:0]        prod
);

    logic [31:0] op_a;
    logic [31:0] op_b;

    // Select operands: generator step or gain scaling
    always_comb
    begin
        case (req.op)
            ksns_pkg::MUL_NOISE:
            begin
                op_a = req.noise;
                op_b = ksns_pkg::NOISE_MULT;
            end
            ksns_pkg::MUL_GAIN:
            begin
                op_a = {{15{req.y[16]}}, req.y};
                op_b = {16'd0, req.gain};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Keep the low word; the gain product fits in 32 bits, the generator step wraps
    assign prod = op_a * op_b;

endmodule

// File: rtl/ksns_ram.sv
module ksns_ram #(
    parameter int DEPTH = 200,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry into the output register
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/ksns_checker.sv
`include "karplus_strong_noise_snare_core_macros.svh"

module ksns_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [14:0] sample
);

    // An accepted transaction keeps the input stalled while it is worked on
    `KSNS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // A result appears only at the end of a busy stretch
    `KSNS_ASSERT_SAME(a_result_after_work, clk, rst_n, $rose(out_valid), $past(in_stall))

    // The block frees its input only as it presents a result
    `KSNS_ASSERT_SAME(a_free_with_result, clk, rst_n, $fell(in_stall), out_valid)

    // A stalled result holds
    `KSNS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(sample))

endmodule

bind karplus_strong_noise_snare_core ksns_checker u_ksns_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample)
);

// File: tb/karplus_strong_noise_snare_core_tb.sv
module karplus_strong_noise_snare_core_tb;

    localparam int TABLE_DEPTH    = 200;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        restart;
    logic        out_valid;
    logic        out_stall;
    logic [14:0] sample;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    // Pluck model state and register copies
    logic signed [15:0] pluck_table [TABLE_DEPTH];
    logic [31:0]        noise_reg;
    logic [31:0]        seed_cfg;
    logic [15:0]        gain_cfg;
    int unsigned        pluck_pos;
    bit                 primed;

    logic [14:0] expected_samples [$];
    int          mismatch_count;
    int          quiet_cycles;
    bit          sender_gaps;
    bit          receiver_gaps;
    bit          hold_off_req;
    int          stall_left;

    karplus_strong_noise_snare_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .restart(restart),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sample(sample),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Gap length: a short range most of the time, a long range one time in sixteen
    function automatic int pick_gap_len();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Reseed the generator and fill the table from it
    task automatic refill_pluck_table();
        noise_reg = seed_cfg;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            pluck_table[i] = ksns_pkg::FILL_BASE + {2'b00, noise_reg[29:16]};
            noise_reg = noise_reg * ksns_pkg::NOISE_MULT;
        end
        pluck_pos = 0;
        primed = 1'b1;
    endtask

    // Advance the string by one sample and return the scaled output
    task automatic predict_sample(input bit rs, output logic [14:0] s);
        int     cur;
        int     nxt;
        int     y;
        longint prod;
        longint q;
        if (rs || !primed)
            refill_pluck_table();
        cur = pluck_pos;
        nxt = (cur + 1) % TABLE_DEPTH;
        y = (int'(pluck_table[cur]) + int'(pluck_table[nxt])) / 2;
        if (noise_reg[16] == 1'b0)
            y = -y;
        noise_reg = noise_reg * ksns_pkg::NOISE_MULT;
        pluck_table[cur] = y[15:0];
        pluck_pos = nxt;
        prod = longint'(y) * longint'(gain_cfg);
        q = prod >>> 16;
        if (q > longint'($signed(ksns_pkg::SAMPLE_MAX)))
            q = longint'($signed(ksns_pkg::SAMPLE_MAX));
        if (q < longint'($signed(ksns_pkg::SAMPLE_MIN)))
            q = longint'($signed(ksns_pkg::SAMPLE_MIN));
        s = q[14:0];
    endtask

    // Offer one transaction, optionally after an idle gap
    task automatic send_item(input bit rs);
        int          gap;
        logic [14:0] s;
        gap = 0;
        if (sender_gaps && $urandom_range(0, 3) == 0)
            gap = pick_gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            restart  <= 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        restart  <= rs;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_sample(rs, s);
        expected_samples.push_back(s);
    endtask

    // Drop the input and wait until every sample has come out
    task automatic drain_outputs();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_index <= 1'($urandom_range(0, 1));
        cfg_data  <= $urandom();
        if (idx == ksns_pkg::REG_NOISE_SEED)
            seed_cfg = data;
        else
            gain_cfg = data[15:0];
    endtask

    task automatic write_gain(input logic [15:0] gain);
        logic [31:0] data;
        data = $urandom();
        data[15:0] = gain;
        write_reg(ksns_pkg::REG_OUT_GAIN, data);
    endtask

    // Reset values: first transaction refills even without restart
    task automatic test_reset_defaults();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        repeat (5) send_item(1'b0);
        send_item(1'b1);
        repeat (2) send_item(1'b0);
        drain_outputs();
    endtask

    // Gain and seed extremes, and seed taking effect only on restart
    task automatic test_register_extremes();
        write_gain(16'd0);
        repeat (2) send_item(1'b0);
        drain_outputs();
        write_gain(16'hffff);
        repeat (2) send_item(1'b0);
        drain_outputs();
        write_gain(16'd32768);
        write_reg(ksns_pkg::REG_NOISE_SEED, 32'h0000_0000);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        drain_outputs();
        write_reg(ksns_pkg::REG_NOISE_SEED, 32'hffff_ffff);
        write_gain(16'd1);
        send_item(1'b1);
        send_item(1'b0);
        drain_outputs();
        write_gain(16'd32769);
        send_item(1'b1);
        send_item(1'b0);
        drain_outputs();
    endtask

    // Hold the output for a long stretch while input keeps coming
    task automatic test_backpressure();
        write_reg(ksns_pkg::REG_NOISE_SEED, $urandom());
        write_gain(16'd32768);
        sender_gaps  = 1'b0;
        hold_off_req = 1'b1;
        send_item(1'b1);
        repeat (39) send_item(1'b0);
        drain_outputs();
    endtask

    // Long random runs across several register settings
    task automatic test_random_runs();
        logic [15:0] gain;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: gain = 16'd32768;
                1: gain = 16'hffff;
                2: gain = 16'd0;
                3: gain = 16'($urandom_range(0, 65535));
                4: gain = 16'($urandom_range(0, 32768));
                default: gain = 16'($urandom_range(32769, 65535));
            endcase
            write_reg(ksns_pkg::REG_NOISE_SEED, $urandom());
            write_gain(gain);
            sender_gaps   = (phase != 0) && (phase != 3);
            receiver_gaps = (phase != 0) && (phase != 4);
            send_item(1'($urandom_range(0, 1)));
            for (int n = 0; n < 290; n++)
                send_item($urandom_range(0, 39) == 0);
            drain_outputs();
        end
    endtask

    // Receiver stall pattern
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (hold_off_req)
            begin
                stall_left   = HOLD_OFF_CYCLES - 1;
                hold_off_req = 1'b0;
                out_stall    <= 1'b1;
            end
            else if (receiver_gaps && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap_len() - 1;
                out_stall  <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted sample with the oldest prediction
    always @(posedge clk)
    begin
        logic [14:0] exp_s;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_samples.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected sample %0d", $signed(sample));
            end
            else
            begin
                exp_s = expected_samples.pop_front();
                if (sample !== exp_s)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("sample mismatch: expected %0d, got %0d",
                                 $signed(exp_s), $signed(sample));
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        restart        = 1'b0;
        out_stall      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = 1'b0;
        cfg_data       = 32'd0;
        seed_cfg       = ksns_pkg::SEED_RESET;
        gain_cfg       = ksns_pkg::GAIN_RESET;
        noise_reg      = 32'd0;
        pluck_pos      = 0;
        primed         = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        sender_gaps    = 1'b0;
        receiver_gaps  = 1'b0;
        hold_off_req   = 1'b0;
        stall_left     = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_backpressure();
        test_random_runs();

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_samples.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
